// ===== src/sfi_pkg.sv =====
// sfi_pkg: shared types and constants for the selectable first-order IIR block.
// Used by sfi_mode_ctrl, sfi_filter and selectable_first_order_iir.
// No dependencies.
`default_nettype none

package sfi_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS       = 8;
    localparam int COEF_BITS       = 15;
    localparam int Y1_BITS         = 24;
    localparam int OUT_BITS        = 14;
    localparam int OUT_MAX         = 8191;

    localparam logic [COEF_BITS-1:0] COEF_RESET = 15'd29491;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } t_mode;

    // button word handed to the mode controller
    typedef struct packed {
        logic strobe;
        logic level;
    } t_btn_evt;

    // item kinds on tuser
    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_ADC    = 1'b1;

endpackage

`default_nettype wire

// ===== src/sfi_mode_ctrl.sv =====
// sfi_mode_ctrl: mode register advanced on each released-after-pressed button edge.
// Depends on sfi_pkg.
`default_nettype none

module sfi_mode_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sfi_pkg::t_btn_evt i_btn,
    output sfi_pkg::t_mode    o_mode
);

    sfi_pkg::t_mode r_mode;
    sfi_pkg::t_mode n_mode;
    logic           r_last;
    logic           n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sfi_pkg::MODE_PASS;
            r_last <= 1'b1;
        end else begin
            r_mode <= n_mode;
            r_last <= n_last;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_last = r_last;
        if (i_btn.strobe) begin
            n_last = i_btn.level;
            if (!r_last && i_btn.level) begin
                case (r_mode)
                    sfi_pkg::MODE_PASS: n_mode = sfi_pkg::MODE_LOW;
                    sfi_pkg::MODE_LOW:  n_mode = sfi_pkg::MODE_HIGH;
                    default:            n_mode = sfi_pkg::MODE_PASS;
                endcase
            end
        end
    end

    assign o_mode = r_mode;

endmodule

`default_nettype wire

// ===== src/sfi_filter.sv =====
// sfi_filter: single-pass low-pass / high-pass / passthrough arithmetic with y1 and x1 state.
// Depends on sfi_pkg.
`default_nettype none

module sfi_filter #(
    parameter int SAMPLE_BITS = sfi_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_update,
    input  sfi_pkg::t_mode                         i_mode,
    input  wire  [sfi_pkg::COEF_BITS-1:0]          i_coef,
    input  wire  [SAMPLE_BITS-1:0]                 i_sample,
    output logic signed [sfi_pkg::OUT_BITS-1:0]    o_filtered
);

    localparam int FB  = sfi_pkg::FRAC_BITS;
    localparam int CB  = sfi_pkg::COEF_BITS;
    localparam int YB  = sfi_pkg::Y1_BITS;
    localparam int OB  = sfi_pkg::OUT_BITS;
    localparam int XW  = SAMPLE_BITS + FB;
    localparam int MW  = (XW > YB) ? XW : YB;
    localparam int AW  = MW + 2;
    localparam int PW  = AW + CB + 2;
    localparam int YW  = MW + 1;

    localparam logic signed [PW-1:0] BIAS_C  = PW'((1 << CB) - 1);
    localparam logic signed [PW-1:0] Y1_HI   = PW'((1 << (YB - 1)) - 1);
    localparam logic signed [PW-1:0] Y1_LO   = -Y1_HI - PW'(1);
    localparam logic signed [YW-1:0] BIAS_F  = YW'((1 << FB) - 1);
    localparam logic signed [YW-1:0] OUT_HI  = YW'(sfi_pkg::OUT_MAX);
    localparam logic signed [YW-1:0] OUT_LO  = -OUT_HI;

    logic signed [YB-1:0]        r_y1;
    logic        [SAMPLE_BITS-1:0] r_x1;

    logic signed [XW:0]          xq;
    logic signed [XW:0]          x1q;
    logic signed [CB+1:0]        gain;
    logic signed [CB+1:0]        coef;
    logic signed [XW+CB+2:0]     lp_px;
    logic signed [YB+CB+1:0]     lp_py;
    logic signed [AW-1:0]        hp_diff;
    logic signed [AW+CB+1:0]     hp_prod;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        rnd_c;
    logic signed [PW-1:0]        sum_c;
    logic signed [PW-1:0]        shf_c;
    logic signed [YB-1:0]        y_filt;
    logic signed [YW-1:0]        yv;
    logic signed [YW-1:0]        rnd_f;
    logic signed [YW-1:0]        yt;

    assign xq    = {1'b0, i_sample, {FB{1'b0}}};
    assign x1q   = {1'b0, r_x1, {FB{1'b0}}};
    assign coef  = {2'b00, i_coef};
    assign gain  = {1'b0, (CB+1)'(1) << CB} - coef;

    assign lp_px   = xq * gain;
    assign lp_py   = r_y1 * coef;
    assign hp_diff = AW'(xq) - AW'(x1q) + AW'(r_y1);
    assign hp_prod = hp_diff * coef;

    always_comb begin
        if (i_mode == sfi_pkg::MODE_HIGH) begin
            prod = PW'(hp_prod);
        end else begin
            prod = PW'(lp_px) + PW'(lp_py);
        end
        // truncate toward zero
        if (prod[PW-1]) begin
            rnd_c = BIAS_C;
        end else begin
            rnd_c = '0;
        end
        sum_c = prod + rnd_c;
        shf_c = sum_c >>> CB;
        if (shf_c > Y1_HI) begin
            y_filt = YB'(Y1_HI);
        end else if (shf_c < Y1_LO) begin
            y_filt = YB'(Y1_LO);
        end else begin
            y_filt = YB'(shf_c);
        end

        if (i_mode == sfi_pkg::MODE_PASS) begin
            yv = YW'(xq);
        end else begin
            yv = YW'(y_filt);
        end
        if (yv[YW-1]) begin
            rnd_f = BIAS_F;
        end else begin
            rnd_f = '0;
        end
        yt = (yv + rnd_f) >>> FB;
        if (yt > OUT_HI) begin
            o_filtered = OB'(OUT_HI);
        end else if (yt < OUT_LO) begin
            o_filtered = OB'(OUT_LO);
        end else begin
            o_filtered = OB'(yt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1 <= '0;
            r_x1 <= '0;
        end else if (i_update) begin
            case (i_mode)
                sfi_pkg::MODE_LOW: begin
                    r_y1 <= y_filt;
                end
                sfi_pkg::MODE_HIGH: begin
                    r_y1 <= y_filt;
                    r_x1 <= i_sample;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/selectable_first_order_iir.sv =====
// selectable_first_order_iir: top level; input register, mode control, filter
// and output register. Depends on sfi_pkg, sfi_mode_ctrl and sfi_filter.
//
// Usage:
//   Slave channel (i_s_*): one word per item. tuser = 0 marks a button level
//   word (tdata bit 0 = level, 0 pressed, 1 released); tuser = 1 marks an ADC
//   word (sample in tdata above the level bit). A press-then-release advances
//   the mode passthrough -> low-pass -> high-pass -> passthrough; button words
//   give no result.
//   Master channel (o_m_*): one result word per ADC word, carrying the sample
//   echo, the filtered value (Q0, saturated to +-8191) and the mode used.
//   Config channel (i_cfg_*): pole coefficient a in Q15, always ready; write
//   it only while no word is in flight.
//   Path: ADC word -> input register -> combinational filter -> output register.
//   Throughput: one word per cycle while i_m_tready is high, set by the filter
//   update (multiply-add feeding y1 back) between input and output registers.
//   Reset: mode is passthrough, button taken as released, x1 and y1 cleared,
//   coefficient 29491 (0.9). Both registers empty.
//   Stall: the output register holds its word while i_m_tready is low; the
//   input register keeps taking words until it holds an ADC word, then tready drops.
`default_nettype none

module selectable_first_order_iir #(
    parameter  int SAMPLE_BITS = sfi_pkg::SAMPLE_BITS_DEF,
    localparam int IN_DW       = ((SAMPLE_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_DW      = ((SAMPLE_BITS + sfi_pkg::OUT_BITS + 2 + 7) / 8) * 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [IN_DW-1:0]                 i_s_tdata,   // button_level, sample
    input  wire                              i_s_tuser,   // req_type
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [OUT_DW-1:0]                o_m_tdata,   // input_echo, filtered, mode_used
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sfi_pkg::COEF_BITS-1:0]    i_cfg_data
);

    localparam int OB = sfi_pkg::OUT_BITS;

    logic [sfi_pkg::COEF_BITS-1:0] r_coef;

    logic                    r_in_valid;
    logic                    r_in_kind;
    logic                    r_in_level;
    logic [SAMPLE_BITS-1:0]  r_in_sample;

    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_echo;
    logic signed [OB-1:0]    r_out_filt;
    sfi_pkg::t_mode          r_out_mode;

    logic                    s_accept;
    logic                    out_free;
    logic                    fire;
    logic                    fire_adc;
    sfi_pkg::t_btn_evt       btn_evt;
    sfi_pkg::t_mode          mode;
    logic signed [OB-1:0]    filt;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign fire        = r_in_valid && ((r_in_kind == sfi_pkg::KIND_BUTTON) || out_free);
    assign fire_adc    = fire && (r_in_kind == sfi_pkg::KIND_ADC);
    assign o_s_tready  = !r_in_valid || fire;
    assign s_accept    = i_s_tvalid && o_s_tready;

    assign btn_evt.strobe = fire && (r_in_kind == sfi_pkg::KIND_BUTTON);
    assign btn_evt.level  = r_in_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= sfi_pkg::COEF_RESET;
        end else if (i_cfg_valid) begin
            r_coef <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_kind   <= i_s_tuser;
            r_in_level  <= i_s_tdata[0];
            r_in_sample <= i_s_tdata[SAMPLE_BITS:1];
        end
    end

    sfi_mode_ctrl u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_btn   (btn_evt),
        .o_mode  (mode)
    );

    sfi_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (fire_adc),
        .i_mode     (mode),
        .i_coef     (r_coef),
        .i_sample   (r_in_sample),
        .o_filtered (filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_adc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_adc) begin
            r_out_echo <= r_in_sample;
            r_out_filt <= filt;
            r_out_mode <= mode;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_out_mode, r_out_filt, r_out_echo});

`ifndef NO_ASSERTIONS
    a_filt_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_filt != {1'b1, {(OB-1){1'b0}}})
        else $error("filtered value outside +-8191");

    a_pass_echo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == sfi_pkg::MODE_PASS
            && (SAMPLE_BITS + OB)'(r_out_echo) <= (SAMPLE_BITS + OB)'(sfi_pkg::OUT_MAX))
        |-> (SAMPLE_BITS + OB)'($unsigned(r_out_filt)) == (SAMPLE_BITS + OB)'(r_out_echo))
        else $error("passthrough result differs from sample");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("pending input word dropped");
`endif

endmodule

`default_nettype wire
